### rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probing hash table
// Key character coding, slot states, ops, status codes and sequencer states.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int unsigned DEF_TABLE_DEPTH   = 64;
    localparam int unsigned DEF_MAX_KEY_CHARS = 8;
    localparam int unsigned HASH_MOD          = 65407;
    localparam int unsigned CODE_BASE         = 2 * 26 + 10;
    localparam int unsigned DIGIT_OFFSET      = 26 + 26;
    localparam int unsigned KEY_W             = 52;
    localparam int unsigned VALUE_W           = 64;
    localparam int unsigned SIZE_W            = 7;
    localparam int unsigned HASH_W            = 16;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADCHAR  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_MOD,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    // code 0..61 in [5:0], bit 6 set when the byte is not alphanumeric
    function automatic logic [6:0] char_code(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h61 && c <= 8'h7a)
            r = {1'b0, 6'(c - 8'h61)};
        else if (c >= 8'h41 && c <= 8'h5a)
            r = {1'b0, 6'(c - 8'h41 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 6'(c - 8'h30 + 8'(DIGIT_OFFSET))};
        else
            r = 7'h40;
        return r;
    endfunction

endpackage

### rtl/core/linear_probing_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probing_hash_table_core: open-addressing key/value table
// A request hashes its key one character at a time, reduces the hash, then
// probes slots one by one, each probe a read followed by a check; the one slot
// memory and the one shared hash/reduce unit set that order. After reset a
// clearing pass marks every slot empty before the first request.
// ----------------------------------------------------------------------------
module linear_probing_hash_table_core #(
    parameter int unsigned TABLE_DEPTH   = lpht_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned MAX_KEY_CHARS = lpht_pkg::DEF_MAX_KEY_CHARS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // key_text[63:0], key_len[67:64], data_in[131:68]
    input  logic [1:0]   s_tuser,  // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // status[1:0], data_out[65:2]
);
    import lpht_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(MAX_KEY_CHARS + 1);
    localparam int unsigned RW = 2 + KEY_W + VALUE_W;
    localparam int unsigned TW = $clog2(TABLE_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic              clr_reg;
    logic [AW-1:0]     clr_idx_reg;
    op_t               op_reg;
    logic [63:0]       text_reg;
    logic [CW-1:0]     len_reg;
    logic [63:0]       data_reg;
    logic [CW-1:0]     ci_reg;
    logic [HASH_W-1:0] acc_reg;
    logic [3:0]        sh_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [AW-1:0]     idx_reg;
    logic [TW-1:0]     cnt_reg;
    logic              ovalid_reg;
    status_t           ostat_reg;
    logic [63:0]       odata_reg;

    logic [TW-1:0]     ts;
    logic [7:0]        ch;
    logic [6:0]        cc;
    logic [HASH_W-1:0] hres;
    logic [22:0]       divisor;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [RW-1:0]     wdata;
    logic [RW-1:0]     rdata;
    slot_t             rstat;
    logic [CW-1:0]     in_len;
    logic              done_fire;
    logic [AW-1:0]     idx_inc;

    assign ts = (size_reg == '0) ? TW'(1) :
                (TW'(size_reg) > TW'(TABLE_DEPTH) || 32'(size_reg) > TABLE_DEPTH)
                ? TW'(TABLE_DEPTH) : TW'(size_reg);
    assign ch = text_reg[7:0];
    assign cc = char_code(ch);
    assign divisor = 23'(ts) << sh_reg;
    assign rstat = slot_t'(rdata[RW-1 -: 2]);
    assign idx_inc = (32'(idx_reg) + 1 == 32'(ts)) ? '0 : AW'(32'(idx_reg) + 1);
    assign in_len = (s_tdata[67:64] > 4'(MAX_KEY_CHARS)) ? CW'(MAX_KEY_CHARS)
                                                         : CW'(s_tdata[67:64]);
    assign s_tready = (state_reg == S_IDLE) && !clr_reg && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = {6'd0, odata_reg, ostat_reg};

    lpht_hash u_hash (
        .mode_reduce (state_reg == S_MOD),
        .acc         (acc_reg),
        .code        (cc[5:0]),
        .divisor     (divisor),
        .result      (hres)
    );

    lpht_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = idx_reg;
        wdata = {SLOT_USED, key_reg, data_reg};
        done_fire = 1'b0;
        if (clr_reg)
        begin
            we = 1'b1;
            waddr = clr_idx_reg;
            wdata = {SLOT_EMPTY, {(RW-2){1'b0}}};
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                    state_next = S_HASH;
            end
            S_HASH:
            begin
                if (ci_reg == len_reg)
                    state_next = S_MOD;
                else if (cc[6])
                    state_next = S_DONE;
            end
            S_MOD:
            begin
                if (sh_reg == 4'd0)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_READ;
                if (op_reg == OP_PUT)
                begin
                    if (rstat != SLOT_USED || rdata[RW-3 -: KEY_W] == key_reg)
                    begin
                        we = 1'b1;
                        wdata = {SLOT_USED, key_reg, data_reg};
                        state_next = S_DONE;
                    end
                end
                else if (rstat == SLOT_EMPTY)
                    state_next = S_DONE;
                else if (rstat == SLOT_USED && rdata[RW-3 -: KEY_W] == key_reg)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        we = 1'b1;
                        wdata = {SLOT_DELETED, rdata[RW-3:0]};
                    end
                    state_next = S_DONE;
                end
                if (state_next != S_DONE && cnt_reg == TW'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                done_fire = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            size_reg    <= SIZE_W'(64);
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (32'(clr_idx_reg) == TABLE_DEPTH - 1)
                    clr_reg <= 1'b0;
            end
            if (done_fire)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg   <= op_t'(s_tuser);
                text_reg <= s_tdata[63:0];
                len_reg  <= in_len;
                data_reg <= s_tdata[131:68];
                ci_reg   <= '0;
                acc_reg  <= '0;
                key_reg  <= {4'(in_len), 48'd0};
                if (!ovalid_reg)
                begin
                    ostat_reg <= ST_NOTFOUND;
                    odata_reg <= '0;
                end
            end
            S_HASH:
            begin
                sh_reg <= 4'd15;
                if (ci_reg != len_reg)
                begin
                    if (cc[6])
                        ostat_reg <= ST_BADCHAR;
                    acc_reg  <= hres;
                    key_reg[6*ci_reg +: 6] <= cc[5:0];
                    text_reg <= text_reg >> 8;
                    ci_reg   <= ci_reg + 1'b1;
                end
            end
            S_MOD:
            begin
                acc_reg <= hres;
                sh_reg  <= sh_reg - 1'b1;
                idx_reg <= AW'(hres);
                cnt_reg <= ts;
                if (op_reg == OP_PUT)
                    ostat_reg <= ST_FULL;
            end
            S_READ:
            begin
            end
            S_CHECK:
            begin
                if (we)
                    ostat_reg <= ST_OK;
                else if (op_reg != OP_PUT && rstat == SLOT_USED
                         && rdata[RW-3 -: KEY_W] == key_reg)
                begin
                    ostat_reg <= ST_OK;
                    odata_reg <= rdata[63:0];
                end
                idx_reg <= idx_inc;
                cnt_reg <= cnt_reg - 1'b1;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram: generic RAM with one write port and one read port
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash: shared multiply-accumulate and reduce unit
// In hash mode folds one character: (acc*62+code) mod 65407. In reduce mode
// subtracts the shifted table size once (restoring division step).
// ----------------------------------------------------------------------------
module lpht_hash (
    input  logic                        mode_reduce,
    input  logic [lpht_pkg::HASH_W-1:0] acc,
    input  logic [5:0]                  code,
    input  logic [22:0]                 divisor,
    output logic [lpht_pkg::HASH_W-1:0] result
);
    import lpht_pkg::*;

    logic [22:0] prod;
    logic [22:0] r1;
    logic [22:0] r2;
    logic [22:0] m1;
    logic [22:0] m2;

    always_comb
    begin
        prod = 23'(acc) * 23'(CODE_BASE) + 23'(code);
        // prod < 62*65407+62, so reduce with q = prod>>16 estimate and fixups
        m1 = 23'(prod[22:16]) * 23'(HASH_MOD);
        r1 = prod - m1;
        r2 = (r1 >= 23'(HASH_MOD)) ? r1 - 23'(HASH_MOD) : r1;
        m2 = (r2 >= 23'(HASH_MOD)) ? r2 - 23'(HASH_MOD) : r2;
        if (mode_reduce)
            result = (23'(acc) >= divisor) ? HASH_W'(23'(acc) - divisor) : acc;
        else
            result = m2[HASH_W-1:0];
    end

endmodule
